### design/h2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package h2rgb_pkg;

  // Q16 fixed point: 1.0 is 65536, so a fraction takes 17 bits.
  localparam int FxW = 17;
  // Helper values may rise a hair above 1.0 after truncation.
  localparam int VW = 18;
  // Signed working width for sums and wraps.
  localparam int SW = 19;
  // Multiplier factor width: 6t on the rising slope and 6(2/3 - t) on the falling one.
  localparam int FW = 16;

  localparam logic [FxW-1:0] FxOne      = 17'd65536;
  localparam logic [FxW-1:0] FxHalf     = 17'd32768;
  localparam logic [FxW-1:0] FxThird    = 17'd21845;
  localparam logic [FxW-1:0] FxTwoThird = 17'd43690;
  // Thresholds of 6t < 1, 2t < 1 and 3t < 2, solved for integer t.
  localparam logic [FxW-1:0] RiseLimit  = 17'd10923;
  localparam logic [FxW-1:0] TopLimit   = 17'd32768;
  localparam logic [FxW-1:0] FallLimit  = 17'd43691;

  typedef enum logic [1:0] {
    REGION_RISE = 2'd0,
    REGION_TOP  = 2'd1,
    REGION_FALL = 2'd2,
    REGION_LOW  = 2'd3
  } region_t;

  typedef struct packed {
    region_t       region;
    logic [FW-1:0] factor;
  } pos_t;

  typedef struct packed {
    logic [VW-1:0]  v1;
    logic [VW-1:0]  v2;
    logic [VW-1:0]  d;
    logic [FxW-1:0] l;
    logic           grey;
  } mix_t;

  // Byte n to Q16, rounded to nearest: n*257 plus one for n of 128 and up.
  function automatic logic [FxW-1:0] byte_to_fx(input logic [7:0] n);
    logic [FxW-1:0] base;
    begin
      base = {1'b0, n, n};
      byte_to_fx = base + {16'd0, n[7]};
    end
  endfunction

  // Wrap a hue position into 0..1 and pick its segment of the channel curve.
  function automatic pos_t hue_pos(input logic signed [SW-1:0] t_in);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] f;
    logic [FxW-1:0]       tu;
    pos_t                 p;
    begin
      t = t_in;
      if (t < 0) begin
        t = t + $signed({2'b00, FxOne});
      end
      if (t > $signed({2'b00, FxOne})) begin
        t = t - $signed({2'b00, FxOne});
      end
      tu = t[FxW-1:0];
      r = $signed({2'b00, FxTwoThird}) - t;
      f = '0;
      if (tu < RiseLimit) begin
        p.region = REGION_RISE;
        f = (t <<< 2) + (t <<< 1);
      end else if (tu < TopLimit) begin
        p.region = REGION_TOP;
      end else if (tu < FallLimit) begin
        p.region = REGION_FALL;
        f = (r <<< 2) + (r <<< 1);
      end else begin
        p.region = REGION_LOW;
      end
      p.factor = f[FW-1:0];
      hue_pos = p;
    end
  endfunction

endpackage

`default_nettype wire

### design/h2rgb_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Stages one to three: byte to Q16, the L*S product, then v1, v2 and the
// three hue positions.
module h2rgb_front (
  input  wire logic                clk,
  input  wire logic [2:0]          en,
  input  wire logic [7:0]          hue,
  input  wire logic [7:0]          saturation,
  input  wire logic [7:0]          lightness,
  output h2rgb_pkg::mix_t          mix,
  output h2rgb_pkg::pos_t          pos_r,
  output h2rgb_pkg::pos_t          pos_g,
  output h2rgb_pkg::pos_t          pos_b
);

  logic [h2rgb_pkg::FxW-1:0] h1, s1, l1;
  logic                      grey1;
  logic [h2rgb_pkg::FxW-1:0] h2, s2, l2, ls2;
  logic                      grey2;
  logic [2*h2rgb_pkg::FxW-1:0] prod_ls;

  logic signed [h2rgb_pkg::SW-1:0] hs, ls_s, ss, lls, v2s, v1s, ds;
  h2rgb_pkg::mix_t mix_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1    <= h2rgb_pkg::byte_to_fx(hue);
      s1    <= h2rgb_pkg::byte_to_fx(saturation);
      l1    <= h2rgb_pkg::byte_to_fx(lightness);
      grey1 <= (saturation == 8'd0);
    end
  end

  assign prod_ls = l1 * s1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      h2    <= h1;
      s2    <= s1;
      l2    <= l1;
      ls2   <= prod_ls[16 +: h2rgb_pkg::FxW];
      grey2 <= grey1;
    end
  end

  always_comb begin
    hs   = $signed({2'b00, h2});
    lls  = $signed({2'b00, l2});
    ss   = $signed({2'b00, s2});
    ls_s = $signed({2'b00, ls2});
    if (l2 < h2rgb_pkg::FxHalf) begin
      v2s = lls + ls_s;
    end else begin
      v2s = lls + ss - ls_s;
    end
    v1s = (lls <<< 1) - v2s;
    if (v1s < 0) begin
      v1s = '0;
    end
    ds = v2s - v1s;
    if (ds < 0) begin
      ds = '0;
    end
    mix_next.v1   = v1s[h2rgb_pkg::VW-1:0];
    mix_next.v2   = v2s[h2rgb_pkg::VW-1:0];
    mix_next.d    = ds[h2rgb_pkg::VW-1:0];
    mix_next.l    = l2;
    mix_next.grey = grey2;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mix   <= mix_next;
      pos_r <= h2rgb_pkg::hue_pos(hs + $signed({2'b00, h2rgb_pkg::FxThird}));
      pos_g <= h2rgb_pkg::hue_pos(hs);
      pos_b <= h2rgb_pkg::hue_pos(hs - $signed({2'b00, h2rgb_pkg::FxThird}));
    end
  end

endmodule

`default_nettype wire

### design/h2rgb_channel.sv
`timescale 1ns / 1ps
`default_nettype none

// Stages four to six of one color channel: slope product, segment select,
// then scaling by 255 with truncation and clamping.
module h2rgb_channel (
  input  wire logic            clk,
  input  wire logic [2:0]      en,
  input  wire h2rgb_pkg::mix_t mix,
  input  wire h2rgb_pkg::pos_t pos,
  output logic [7:0]           chan
);

  localparam int PW = h2rgb_pkg::VW + h2rgb_pkg::FW;
  localparam int CW = h2rgb_pkg::VW + 8;

  logic [PW-1:0]              prod;
  logic [h2rgb_pkg::VW-1:0]   slope4;
  h2rgb_pkg::mix_t            mix4;
  h2rgb_pkg::region_t         region4;
  logic [h2rgb_pkg::VW-1:0]   c_next;
  logic [h2rgb_pkg::VW-1:0]   c5;
  logic [CW-1:0]              scaled;
  logic [CW-17:0]             whole;

  assign prod = mix.d * pos.factor;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      slope4  <= prod[PW-1:16];
      mix4    <= mix;
      region4 <= pos.region;
    end
  end

  always_comb begin
    case (region4)
      h2rgb_pkg::REGION_RISE: c_next = mix4.v1 + slope4;
      h2rgb_pkg::REGION_TOP:  c_next = mix4.v2;
      h2rgb_pkg::REGION_FALL: c_next = mix4.v1 + slope4;
      h2rgb_pkg::REGION_LOW:  c_next = mix4.v1;
      default:                c_next = mix4.v1;
    endcase
    if (mix4.grey) begin
      c_next = {1'b0, mix4.l};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c5 <= c_next;
    end
  end

  assign scaled = {c5, 8'd0} - {8'd0, c5};
  assign whole  = scaled[CW-1:16];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      chan <= (whole > 10'd255) ? 8'd255 : whole[7:0];
    end
  end

endmodule

`default_nettype wire

### design/hsl_to_rgb24_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

// HSL to RGB24 pixel converter.
//
// Each item on the slave stream (s_tvalid, s_tready, s_tdata) is one pixel
// given as hue, saturation and lightness bytes, each a fraction n/255. Each
// item on the master stream (m_tvalid, m_tready, m_tdata) is the matching
// pixel as red, green and blue bytes, in the same order as the inputs.
//
// The datapath is a six stage pipeline: byte to Q16 conversion, the L*S
// multiply, the v1/v2 helpers and hue positions, the per-channel slope
// multiply, the segment select, and the scale by 255 into the output
// register. One item is accepted every cycle while the receiver keeps
// m_tready high.
//
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so empty slots fill up while the receiver stalls and
// s_tready only falls once all six stages hold items. Nothing is dropped or
// repeated across a stall. Reset clears the valid bits only; the pipeline
// comes out of reset empty and ready.
module hsl_to_rgb24_pixel (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // Fields from bit 0: hue[7:0], saturation[15:8], lightness[23:16].
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
  output logic [23:0]      m_tdata
);

  localparam int Stages = 6;

  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;

  h2rgb_pkg::mix_t mix;
  h2rgb_pkg::pos_t pos_r, pos_g, pos_b;
  logic [7:0] red, green, blue;

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    en[Stages-1] = !vld[Stages-1] || m_tready;
    for (int k = Stages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < Stages; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[Stages-1];
  assign m_tdata  = {blue, green, red};

  h2rgb_front u_front (
    .clk        (clk),
    .en         (en[2:0]),
    .hue        (s_tdata[7:0]),
    .saturation (s_tdata[15:8]),
    .lightness  (s_tdata[23:16]),
    .mix        (mix),
    .pos_r      (pos_r),
    .pos_g      (pos_g),
    .pos_b      (pos_b)
  );

  h2rgb_channel u_red (
    .clk  (clk),
    .en   (en[5:3]),
    .mix  (mix),
    .pos  (pos_r),
    .chan (red)
  );

  h2rgb_channel u_green (
    .clk  (clk),
    .en   (en[5:3]),
    .mix  (mix),
    .pos  (pos_g),
    .chan (green)
  );

  h2rgb_channel u_blue (
    .clk  (clk),
    .en   (en[5:3]),
    .mix  (mix),
    .pos  (pos_b),
    .chan (blue)
  );

  // An accepted item always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> vld[0])
    else $error("accepted item missing from first stage");

  // A receiver that is ready means the whole pipeline can move.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output is taken");

  // A held stage keeps its item through a stall.
  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    vld[2] && !en[2] |=> vld[2])
    else $error("stalled item lost in stage three");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("stalled result lost at output");

endmodule

`default_nettype wire
